FILE: rtl/dedup_front_insert_deque_defines.svh
// assertion macros shared by the deque rtl
// no dependencies; included by files that carry concurrent checks
`ifndef DEDUP_FRONT_INSERT_DEQUE_DEFINES_SVH
`define DEDUP_FRONT_INSERT_DEQUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DFID_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfid check failed");

// next-cycle implication, disabled during reset
`define DFID_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfid check failed");

`endif

FILE: rtl/dfid_pkg.sv
// shared types and constants for the duplicate-rejecting deque
// no dependencies; imported by dfid_cell and dedup_front_insert_deque
`timescale 1ns / 1ps
`default_nettype none

package dfid_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_COMMIT
  } state_t;

  // move command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop_front;
    logic pop_back;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/dedup_front_insert_deque.sv
// Duplicate-rejecting deque of signed 32-bit values, front insert only.
// Input channel: in_valid/in_ready with operation and value. operation 0
// inserts value at the front unless it is already stored or the store is
// full, 1 pops the front, 2 pops the back, 3 does nothing.
// Output channel: out_valid/out_ready with removed_value and status
// (ok, duplicate, full, empty); exactly one result per input transfer.
// Sequence: the item is registered on the input transfer, every cell then
// registers its own compare and tail pick, and the commit state reduces
// those bits, moves the chain and registers the result, raising out_valid.
// Items are handled one at a time: no new item is taken until the commit.
// Reset: synchronous, empties the store and drops any pending result.
// Stall: a held result waits in the output register; the commit cycle waits
// until the register is free, and no new item is taken until then.
// Depends on dfid_pkg, dfid_cell and dedup_front_insert_deque_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "dedup_front_insert_deque_defines.svh"

module dedup_front_insert_deque (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [dfid_pkg::OP_W-1:0]        operation,
  input  wire logic signed [dfid_pkg::DATA_W-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [dfid_pkg::DATA_W-1:0]    removed_value,
  output logic [dfid_pkg::STAT_W-1:0]           status
);
  import dfid_pkg::*;

  state_t state, state_next;

  logic [OP_W-1:0]   req_op;
  logic [DATA_W-1:0] req_val;

  cell_cmd_t cmd;
  logic [DEPTH-1:0]  occ_vec;
  logic [DEPTH-1:0]  hit_vec;
  logic [DATA_W-1:0] data_arr [DEPTH];
  logic [DATA_W-1:0] tail_arr [DEPTH];

  logic              any_hit;
  logic [DATA_W-1:0] tail_val;
  logic              commit;
  logic [DATA_W-1:0] res_val;
  logic [STAT_W-1:0] res_stat;

  // cell chain: cell 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] l_data, r_data;
    logic              l_occ, r_occ;
    if (i == 0) begin : g_head
      assign l_data = req_val;
      assign l_occ  = 1'b1;
    end else begin : g_mid
      assign l_data = data_arr[i-1];
      assign l_occ  = occ_vec[i-1];
    end
    if (i == DEPTH-1) begin : g_tail
      assign r_data = '0;
      assign r_occ  = 1'b0;
    end else begin : g_inner
      assign r_data = data_arr[i+1];
      assign r_occ  = occ_vec[i+1];
    end
    dfid_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .key       (req_val),
      .left_data (l_data),
      .left_occ  (l_occ),
      .right_data(r_data),
      .right_occ (r_occ),
      .data      (data_arr[i]),
      .occ       (occ_vec[i]),
      .hit       (hit_vec[i]),
      .tail_val  (tail_arr[i])
    );
  end

  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | tail_arr[i];
    end
  end
  assign any_hit = |hit_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op  <= operation;
      req_val <= value;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // decide the result and the chain move
  always_comb begin
    cmd      = '0;
    res_val  = '0;
    res_stat = STAT_OK;
    case (req_op)
      OP_INSERT: begin
        if (any_hit) begin
          res_stat = STAT_DUP;
        end else if (occ_vec[DEPTH-1]) begin
          res_stat = STAT_FULL;
        end else begin
          cmd.ins = commit;
        end
      end
      OP_POP_FRONT: begin
        if (!occ_vec[0]) begin
          res_stat = STAT_EMPTY;
        end else begin
          res_val       = data_arr[0];
          cmd.pop_front = commit;
        end
      end
      OP_POP_BACK: begin
        if (!occ_vec[0]) begin
          res_stat = STAT_EMPTY;
        end else begin
          res_val      = tail_val;
          cmd.pop_back = commit;
        end
      end
      default: begin
        res_stat = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      removed_value <= res_val;
      status        <= res_stat;
    end
  end

  // occupied cells form one run starting at the front
  `DFID_ASSERT_IMP(a_occ_contiguous, clk, rst, 1'b1, ((occ_vec >> 1) & ~occ_vec) == '0)
  // a result appears only out of the commit cycle
  `DFID_ASSERT_IMP(a_result_from_commit, clk, rst, $rose(out_valid), $past(state) == ST_COMMIT)
  // an accepted insert leaves the front cell occupied
  `DFID_ASSERT_NXT(a_insert_fills_front, clk, rst, commit && cmd.ins, occ_vec[0])
  // a rejected or empty-store transfer leaves the chain alone
  `DFID_ASSERT_NXT(a_reject_holds, clk, rst, commit && res_stat != STAT_OK, $stable(occ_vec))

endmodule

`default_nettype wire

FILE: rtl/dfid_cell.sv
// one storage cell of the deque chain: entry, occupied flag, compare
// depends on dfid_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfid_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dfid_pkg::cell_cmd_t     cmd,
  input  wire logic [dfid_pkg::DATA_W-1:0] key,
  input  wire logic [dfid_pkg::DATA_W-1:0] left_data,
  input  wire logic                    left_occ,
  input  wire logic [dfid_pkg::DATA_W-1:0] right_data,
  input  wire logic                    right_occ,
  output logic [dfid_pkg::DATA_W-1:0]  data,
  output logic                         occ,
  output logic                         hit,
  output logic [dfid_pkg::DATA_W-1:0]  tail_val
);
  import dfid_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (cmd.ins) begin
      occ <= left_occ;
    end else if (cmd.pop_front) begin
      occ <= right_occ;
    end else if (cmd.pop_back) begin
      // only the last occupied cell lets go
      occ <= occ & right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      data <= left_data;
    end else if (cmd.pop_front) begin
      data <= right_data;
    end
  end

  // registered compare and tail pick, reduced by the controller next cycle
  always_ff @(posedge clk) begin
    hit      <= occ && (data == key);
    tail_val <= (occ && !right_occ) ? data : '0;
  end

endmodule

`default_nettype wire
